### rtl/ssp_pkg.sv
// package: shared types, states and constants for the prime test
`default_nettype none
package ssp_pkg;
    localparam int unsigned CandW = 32;
    localparam int unsigned RandW = 31;

    typedef struct packed {
        logic [CandW-1:0] candidate;
        logic [RandW-1:0] random_word;
    } t_in_beat;

    typedef struct packed {
        logic       probable_prime;
        logic [1:0] verdict_cause;
    } t_out_beat;

    typedef enum logic [1:0] {
        CAUSE_SMALL  = 2'd0,
        CAUSE_EVEN   = 2'd1,
        CAUSE_FACTOR = 2'd2,
        CAUSE_EULER  = 2'd3
    } t_cause;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WIT_START,
        OP_GCD_INIT,
        OP_GCD_START,
        OP_GCD_SWAP,
        OP_POW_INIT,
        OP_POW_MUL_ACC,
        OP_POW_MUL_BASE,
        OP_JAC_INIT,
        OP_JAC_STEP,
        OP_JAC_START,
        OP_JAC_SWAP
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic       le_three;
        logic       small_prime;
        logic       even;
        logic       div_busy;
        logic       gcd_done;
        logic       gcd_shared;
        logic       exp_zero;
        logic       exp_odd;
        logic       jac_x_zero;
        logic       jac_x_even;
        logic       verdict;
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_WIT_WAIT,
        ST_GCD_INIT,
        ST_GCD_CHECK,
        ST_GCD_WAIT,
        ST_GCD_SWAP,
        ST_POW_INIT,
        ST_POW_CHECK,
        ST_POW_ACC_WAIT,
        ST_POW_BASE,
        ST_POW_BASE_WAIT,
        ST_JAC_INIT,
        ST_JAC_WAIT0,
        ST_JAC_CHECK,
        ST_JAC_WAIT,
        ST_JAC_SWAP,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

### rtl/solovay_strassen_prime_test.sv
// top level: one solovay-strassen round per input beat
// candidates below four and even ones are settled by the classify step alone; odd ones
//   also run the witness remainder, the gcd, the power loop and the jacobi loop on the
//   shared remainder unit: the power loop up to 2*(NUM_WIDTH-1) remainders, gcd and
//   jacobi up to about 1.5*NUM_WIDTH each
// throughput: one beat in flight; a finished result may wait while the next beat is taken
// reset: synchronous active-low i_rst_n clears the controller and the result valid
`default_nettype none
module solovay_strassen_prime_test #(
    parameter int unsigned NUM_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ssp_pkg::t_in_beat   i_in_beat,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ssp_pkg::t_out_beat       o_out_beat
);
    import ssp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // controller owns the handshake and the result register
    ssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // datapath holds n, witness, gcd/jacobi pair and the power registers
    ssp_datapath #(.W(NUM_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_beat  (i_in_beat),
        .o_status(status)
    );
endmodule
`default_nettype wire

### rtl/ssp_divider.sv
// divider: restoring remainder of an NW-bit dividend by a W-bit divisor, one bit a cycle
`default_nettype none
module ssp_divider #(
    parameter int unsigned W  = 32,
    parameter int unsigned NW = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [NW-1:0]  i_dividend,
    input  wire logic [W-1:0]   i_divisor,
    output logic                o_busy,
    output logic [W-1:0]        o_rem
);
    localparam int unsigned CntW = $clog2(NW+1);

    logic [NW-1:0]  r_num, n_num;
    logic [W:0]     r_rem, n_rem;
    logic [W-1:0]   r_div;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic [W:0]     shifted;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        shifted = {r_rem[W-1:0], r_num[NW-1]};
        if (i_start) begin
            n_num  = i_dividend;
            n_rem  = '0;
            n_cnt  = CntW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NW-2:0], 1'b0};
            if (shifted >= {1'b0, r_div}) begin
                n_rem = shifted - {1'b0, r_div};
            end else begin
                n_rem = shifted;
            end
            n_cnt = r_cnt - CntW'(1);
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[W-1:0];
endmodule
`default_nettype wire

### rtl/ssp_datapath.sv
// datapath: operand registers, multiplier and shared remainder unit
`default_nettype none
module ssp_datapath #(
    parameter int unsigned W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssp_pkg::t_cmd     i_cmd,
    input  wire ssp_pkg::t_in_beat i_beat,
    output ssp_pkg::t_status       o_status
);
    import ssp_pkg::*;

    // dividend wide enough for a full product and for the whole random word
    localparam int unsigned DivW = (2*W > RandW) ? 2*W : RandW;

    logic [W-1:0] r_n, r_a, r_x, r_y, r_acc, r_base, r_exp;
    logic         r_sign;
    logic [RandW-1:0] r_rnd;
    logic         r_pend_acc, r_pend_base, r_pend_jac;
    logic         div_start;
    logic [DivW-1:0] div_num;
    logic [W-1:0] div_den, div_rem;
    logic         div_busy;
    logic [W-1:0] mul_lhs;
    logic [2*W-1:0] prod;
    logic [2:0]   m8;
    logic [W-1:0] nm1;

    ssp_divider #(.W(W), .NW(DivW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_num),
        .i_divisor (div_den),
        .o_busy    (div_busy),
        .o_rem     (div_rem)
    );

    assign m8  = r_y[2:0];
    assign nm1 = r_n - W'(1);

    // one multiplier: acc*base or base*base, fed straight into the divider
    assign mul_lhs = (i_cmd.op == OP_POW_MUL_ACC) ? r_acc : r_base;
    assign prod    = {{W{1'b0}}, mul_lhs} * {{W{1'b0}}, r_base};

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = r_n;
        unique case (i_cmd.op)
            OP_WIT_START: begin
                div_start = 1'b1;
                div_num   = DivW'(r_rnd);
                div_den   = r_n - W'(3);
            end
            OP_GCD_START: begin
                div_start = 1'b1;
                div_num   = DivW'(r_x);
                div_den   = r_y;
            end
            OP_POW_MUL_ACC, OP_POW_MUL_BASE: begin
                div_start = 1'b1;
                div_num   = DivW'(prod);
            end
            OP_JAC_INIT: begin
                div_start = 1'b1;
                div_num   = DivW'(r_a);
            end
            OP_JAC_START: begin
                // swap step: new x is m mod x
                div_start = 1'b1;
                div_num   = DivW'(r_y);
                div_den   = r_x;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_NONE: begin
                // write back the remainder once the divider settles
                if (r_pend_acc && !div_busy) begin
                    r_acc <= div_rem;
                end
                if (r_pend_base && !div_busy) begin
                    r_base <= div_rem;
                    r_exp  <= r_exp >> 1;
                end
                if (r_pend_jac && !div_busy) begin
                    r_x <= div_rem;
                end
            end
            OP_LOAD: begin
                r_n   <= i_beat.candidate[W-1:0];
                r_rnd <= i_beat.random_word;
            end
            OP_GCD_INIT: begin
                r_a <= div_rem + W'(2);
                r_x <= div_rem + W'(2);
                r_y <= r_n;
            end
            OP_GCD_SWAP: begin
                r_x <= r_y;
                r_y <= div_rem;
            end
            OP_POW_INIT: begin
                r_acc  <= W'(1);
                r_base <= r_a;
                r_exp  <= nm1 >> 1;
            end
            OP_JAC_INIT: begin
                r_y    <= r_n;
                r_sign <= 1'b1;
            end
            OP_JAC_STEP: begin
                r_x <= r_x >> 1;
                if (m8 == 3'd3 || m8 == 3'd5) begin
                    r_sign <= ~r_sign;
                end
            end
            OP_JAC_SWAP: begin
                r_x <= div_rem;
                r_y <= r_x;
                if (r_x[1:0] == 2'd3 && r_y[1:0] == 2'd3) begin
                    r_sign <= ~r_sign;
                end
            end
            default: ;
        endcase
    end

    // pending write-back flags, held until the divider goes idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_acc  <= 1'b0;
            r_pend_base <= 1'b0;
            r_pend_jac  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_POW_MUL_ACC) begin
                r_pend_acc <= 1'b1;
            end else if (r_pend_acc && !div_busy) begin
                r_pend_acc <= 1'b0;
            end
            if (i_cmd.op == OP_POW_MUL_BASE) begin
                r_pend_base <= 1'b1;
            end else if (r_pend_base && !div_busy) begin
                r_pend_base <= 1'b0;
            end
            if (i_cmd.op == OP_JAC_INIT) begin
                r_pend_jac <= 1'b1;
            end else if (r_pend_jac && !div_busy) begin
                r_pend_jac <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.le_three    = (r_n <= W'(3));
        o_status.small_prime = (r_n >= W'(2));
        o_status.even        = ~r_n[0];
        o_status.div_busy    = div_busy | r_pend_acc | r_pend_base | r_pend_jac;
        o_status.gcd_done    = (r_y == '0);
        o_status.gcd_shared  = (r_x != W'(1));
        o_status.exp_zero    = (r_exp == '0);
        o_status.exp_odd     = r_exp[0];
        o_status.jac_x_zero  = (r_x == '0);
        o_status.jac_x_even  = ~r_x[0];
        o_status.verdict     = (r_y == W'(1)) &&
                               ((r_sign && r_acc == W'(1)) || (!r_sign && r_acc == nm1));
    end
endmodule
`default_nettype wire

### rtl/ssp_ctrl.sv
// controller: sequences classify, witness, gcd, power and jacobi phases
`default_nettype none
module ssp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ssp_pkg::t_out_beat      o_out_beat,
    output ssp_pkg::t_cmd           o_cmd,
    input  wire ssp_pkg::t_status   i_status
);
    import ssp_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    t_out_beat r_res, n_res;
    t_out_beat r_work, n_work;   // verdict of the beat in progress

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_res   = r_res;
        n_work  = r_work;
        if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CLASSIFY;
            ST_CLASSIFY: begin
                if (i_status.le_three) begin
                    n_work  = '{probable_prime: i_status.small_prime, verdict_cause: CAUSE_SMALL};
                    n_state = ST_DONE;
                end else if (i_status.even) begin
                    n_work  = '{probable_prime: 1'b0, verdict_cause: CAUSE_EVEN};
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_WIT_WAIT;
                end
            end
            ST_WIT_WAIT: if (!i_status.div_busy) n_state = ST_GCD_INIT;
            ST_GCD_INIT: n_state = ST_GCD_CHECK;
            ST_GCD_CHECK: begin
                if (i_status.gcd_done) begin
                    if (i_status.gcd_shared) begin
                        n_work  = '{probable_prime: 1'b0, verdict_cause: CAUSE_FACTOR};
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_POW_INIT;
                    end
                end else begin
                    n_state = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: if (!i_status.div_busy) n_state = ST_GCD_SWAP;
            ST_GCD_SWAP: n_state = ST_GCD_CHECK;
            ST_POW_INIT: n_state = ST_POW_CHECK;
            ST_POW_CHECK: begin
                if (i_status.exp_zero) begin
                    n_state = ST_JAC_INIT;
                end else if (i_status.exp_odd) begin
                    n_state = ST_POW_ACC_WAIT;
                end else begin
                    n_state = ST_POW_BASE;
                end
            end
            ST_POW_ACC_WAIT: if (!i_status.div_busy) n_state = ST_POW_BASE;
            ST_POW_BASE: n_state = ST_POW_BASE_WAIT;
            ST_POW_BASE_WAIT: if (!i_status.div_busy) n_state = ST_POW_CHECK;
            ST_JAC_INIT: n_state = ST_JAC_WAIT0;
            ST_JAC_WAIT0: if (!i_status.div_busy) n_state = ST_JAC_CHECK;
            ST_JAC_CHECK: begin
                if (i_status.jac_x_zero) begin
                    n_work  = '{probable_prime: i_status.verdict, verdict_cause: CAUSE_EULER};
                    n_state = ST_DONE;
                end else if (i_status.jac_x_even) begin
                    n_state = ST_JAC_CHECK;
                end else begin
                    n_state = ST_JAC_WAIT;
                end
            end
            ST_JAC_WAIT: if (!i_status.div_busy) n_state = ST_JAC_SWAP;
            ST_JAC_SWAP: n_state = ST_JAC_CHECK;
            ST_DONE: begin
                // hand over once the output register is free
                if (!n_valid) begin
                    n_res   = r_work;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command decode; multiply steps feed the product straight to the divider
    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) o_cmd.op = OP_LOAD;
            ST_CLASSIFY:  if (!i_status.le_three && !i_status.even) o_cmd.op = OP_WIT_START;
            ST_GCD_INIT:  o_cmd.op = OP_GCD_INIT;
            ST_GCD_CHECK: if (!i_status.gcd_done) o_cmd.op = OP_GCD_START;
            ST_GCD_SWAP:  o_cmd.op = OP_GCD_SWAP;
            ST_POW_INIT:  o_cmd.op = OP_POW_INIT;
            ST_POW_CHECK: if (!i_status.exp_zero && i_status.exp_odd)
                              o_cmd.op = OP_POW_MUL_ACC;
            ST_POW_BASE:  o_cmd.op = OP_POW_MUL_BASE;
            ST_JAC_INIT:  o_cmd.op = OP_JAC_INIT;
            ST_JAC_CHECK: begin
                if (!i_status.jac_x_zero) begin
                    o_cmd.op = i_status.jac_x_even ? OP_JAC_STEP : OP_JAC_START;
                end
            end
            ST_JAC_SWAP:  o_cmd.op = OP_JAC_SWAP;
            default:      o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_res  <= n_res;
        r_work <= n_work;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_valid;
    assign o_out_beat  = r_res;
endmodule
`default_nettype wire

### bench/prime_verdict_checker.sv
// checker: predicts each prime-test verdict and compares it with the block's output
`timescale 1ns / 100ps
module prime_verdict_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire ssp_pkg::t_in_beat  i_in_beat,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire ssp_pkg::t_out_beat i_out_beat,
    output int                      o_fail_count,
    output int                      o_pending
);
    import ssp_pkg::*;

    t_out_beat verdict_q[$];

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [63:0] modexp(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic int jacobi(logic [63:0] x, logic [63:0] m);
        int sgn;
        logic [63:0] t;
        sgn = 1;
        x = x % m;
        while (x != 0) begin
            while (x[0] == 1'b0) begin
                x = x >> 1;
                if (m[2:0] == 3'd3 || m[2:0] == 3'd5) sgn = -sgn;
            end
            t = x;
            x = m;
            m = t;
            if (x[1:0] == 2'd3 && m[1:0] == 2'd3) sgn = -sgn;
            x = x % m;
        end
        return (m == 1) ? sgn : 0;
    endfunction

    function automatic t_out_beat predict_verdict(t_in_beat b);
        t_out_beat v;
        logic [63:0] n, r, a, x;
        int j;
        n = {32'd0, b.candidate};
        r = {33'd0, b.random_word};
        if (n <= 1) begin
            v.probable_prime = 1'b0;
            v.verdict_cause = CAUSE_SMALL;
        end else if (n <= 3) begin
            v.probable_prime = 1'b1;
            v.verdict_cause = CAUSE_SMALL;
        end else if (n[0] == 1'b0) begin
            v.probable_prime = 1'b0;
            v.verdict_cause = CAUSE_EVEN;
        end else begin
            a = 2 + r % (n - 3);
            if (gcd64(a, n) > 1) begin
                v.probable_prime = 1'b0;
                v.verdict_cause = CAUSE_FACTOR;
            end else begin
                x = modexp(a, (n - 1) >> 1, n);
                j = jacobi(a, n);
                v.probable_prime = (j == 1 && x == 1) || (j == -1 && x == n - 1);
                v.verdict_cause = CAUSE_EULER;
            end
        end
        return v;
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                verdict_q.push_back(predict_verdict(i_in_beat));
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected beat: %b/%0d", i_out_beat.probable_prime,
                                 i_out_beat.verdict_cause);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== i_out_beat) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected prime %b cause %0d, got %b cause %0d",
                                     want.probable_prime, want.verdict_cause,
                                     i_out_beat.probable_prime, i_out_beat.verdict_cause);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### bench/testbench.sv
// testbench top: stimulus for the prime test block and the final verdict
`timescale 1ns / 100ps
module testbench;
    import ssp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_beat in_beat = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    t_out_beat out_beat;
    int fail_count;
    int pending;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    solovay_strassen_prime_test u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_beat(in_beat),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_beat(out_beat)
    );

    prime_verdict_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_beat(in_beat),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_beat(out_beat),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // known primes and tricky composites (carmichael numbers, a prime square, others)
    logic [31:0] primes[8] = '{32'd5, 32'd7, 32'd13, 32'd65537, 32'd2147483647,
                               32'd4294967291, 32'd4294967279, 32'd104729};
    logic [31:0] odd_comp[6] = '{32'd9, 32'd561, 32'd1105, 32'd41041, 32'd4294967295,
                                 32'd10403};

    // one beat; random pause first, then hold until accepted
    task automatic send_beat(logic [31:0] cand, logic [31:0] rw);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        repeat (gap) @(negedge i_clk);
        in_beat.candidate <= cand;
        in_beat.random_word <= rw[30:0];
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_candidate();
        case ($urandom_range(0, 5))
            0: return primes[$urandom_range(0, 7)];
            1: return odd_comp[$urandom_range(0, 5)];
            2: return $urandom_range(0, 64);
            3: return $urandom | 32'h1;
            4: return $urandom_range(5, 5000) | 32'h1;
            default: return $urandom;
        endcase
    endfunction

    // receiver stall: random stretches per result
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            out_stall <= (hold != 0);
            repeat (hold) @(negedge i_clk);
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int k;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: small rule, even, extremes, factor, euler
        send_beat(32'd0, 32'd0);
        send_beat(32'd1, 32'h7fffffff);
        send_beat(32'd2, 32'd5);
        send_beat(32'd3, 32'd0);
        send_beat(32'd4, 32'd0);
        send_beat(32'hfffffffe, 32'h7fffffff);
        send_beat(32'h80000000, 32'd1);
        send_beat(32'd5, 32'd0);
        send_beat(32'd5, 32'h7fffffff);
        send_beat(32'd9, 32'd1);
        send_beat(32'd15, 32'd1);
        send_beat(32'd561, 32'd1);
        send_beat(32'hffffffff, 32'h7fffffff);
        send_beat(32'd4294967291, 32'h7fffffff);
        send_beat(32'd4294967291, 32'd0);
        send_beat(32'd2147483647, 32'h55555555);
        send_beat(32'd1105, 32'h2aaaaaaa);
        send_beat(32'd7, 32'h7ffffffe);
        send_beat(32'd65537, 32'd12345);
        send_beat(32'd10403, 32'd99);
        for (k = 0; k < 300; k++)
            send_beat(rand_candidate(), $urandom);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // time limit for roughly 320 beats, with wide margin
    initial begin
        #500ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
